/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define AM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* sv/ohalloc_pkg.sv */
// ----------------------------------------------------------------------------
// ohalloc_pkg
// Types, constants and handle helpers shared by the object handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ohalloc_pkg;

    localparam int FIELD_BITS   = 8;
    localparam int INDEX_BITS   = 32;
    localparam int HANDLE_W     = 64;
    localparam int SWITCH_SLOTS = 255;
    localparam int TYPE_SLOTS   = 256;

    localparam int CTR_W     = INDEX_BITS + 1;
    localparam int TYPE_AW   = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
    localparam int SLOT_SPAN = 2 ** FIELD_BITS;
    localparam int GRP_BITS  = 4;
    localparam int GRP_SIZE  = 2 ** GRP_BITS;
    localparam int GRPS      = SLOT_SPAN / GRP_SIZE;
    localparam int GRP_AW    = FIELD_BITS - GRP_BITS;

    localparam int TYPE_LSB = INDEX_BITS;
    localparam int SLOT_LSB = INDEX_BITS + FIELD_BITS;
    localparam int CTX_LSB  = INDEX_BITS + 2 * FIELD_BITS;
    localparam int RSV_W    = HANDLE_W - INDEX_BITS - 3 * FIELD_BITS;

    typedef logic [FIELD_BITS-1:0] t_field;
    typedef logic [HANDLE_W-1:0]   t_handle;

    typedef enum logic [2:0] {
        MODE_ALLOC      = 3'd0,
        MODE_RELEASE    = 3'd1,
        MODE_SW_QUERY   = 3'd2,
        MODE_TYPE_QUERY = 3'd3,
        MODE_WARM_BOOT  = 3'd4,
        MODE_CLEAR      = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_TYPE   = 3'd1,
        ST_NO_SLOT    = 3'd2,
        ST_EXHAUSTED  = 3'd3,
        ST_NOT_IN_USE = 3'd4,
        ST_NOT_SWITCH = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_CONTEXT     = 2'd0,
        CFG_SWITCH_TYPE = 2'd1,
        CFG_TYPE_LIMIT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic      set;
        logic      clr;
        logic      clr_all;
        t_field    idx;
    } t_slot_cmd;

    typedef struct packed {
        logic               en;
        logic               clr_all;
        logic [TYPE_AW-1:0] addr;
        logic [CTR_W-1:0]   data;
    } t_ctr_wr;

    function automatic t_field type_field(input t_handle h);
        return h[TYPE_LSB +: FIELD_BITS];
    endfunction

    function automatic t_field slot_field(input t_handle h);
        return h[SLOT_LSB +: FIELD_BITS];
    endfunction

    function automatic t_field decode_type(input t_handle h, input t_field limit);
        t_field t;
        t = type_field(h);
        if (h == '0 || t == '0 || t >= limit) begin
            return '0;
        end
        return t;
    endfunction

    function automatic t_handle make_handle(input t_field ctx, input t_field slot,
                                            input t_field typ,
                                            input logic [INDEX_BITS-1:0] idx);
        return {{RSV_W{1'b0}}, ctx, slot, typ, idx};
    endfunction

    function automatic logic type_in_table(input t_field t);
        return int'(t) < TYPE_SLOTS;
    endfunction

    function automatic logic slot_in_range(input t_field s);
        return int'(s) < SWITCH_SLOTS;
    endfunction

endpackage

`default_nettype wire

/* sv/ohalloc_ctr_mem.sv */
// ----------------------------------------------------------------------------
// ohalloc_ctr_mem
// Per-type index counter table: a synchronous memory with a registered read
// port and a valid bit per entry so that reset and clear zero it at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ohalloc_ctr_mem (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [ohalloc_pkg::TYPE_AW-1:0] i_rd_addr,
    input  wire ohalloc_pkg::t_ctr_wr           i_wr,
    output logic [ohalloc_pkg::CTR_W-1:0]       o_rd_data
);
    import ohalloc_pkg::*;

    logic [CTR_W-1:0]      r_mem [TYPE_SLOTS];
    logic [TYPE_SLOTS-1:0] r_vld;
    logic [CTR_W-1:0]      r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            if (i_wr.clr_all) begin
                r_vld <= '0;
            end else if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

/* sv/ohalloc_slot_map.sv */
// ----------------------------------------------------------------------------
// ohalloc_slot_map
// Switch slot bitmap with a registered per-group free summary and a two-level
// search for the lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ohalloc_slot_map (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ohalloc_pkg::t_slot_cmd i_cmd,
    input  wire ohalloc_pkg::t_field    i_query,
    output logic                        o_in_use,
    output logic                        o_free_found,
    output ohalloc_pkg::t_field         o_free_idx
);
    import ohalloc_pkg::*;

    logic [SLOT_SPAN-1:0] r_slot;
    logic [SLOT_SPAN-1:0] n_slot;
    logic [GRPS-1:0]      r_grp_free;
    logic [SLOT_SPAN-1:0] w_free;
    logic [GRP_AW-1:0]    w_grp_sel;
    logic [GRP_SIZE-1:0]  w_grp_bits;
    logic [GRP_BITS-1:0]  w_bit_sel;

    function automatic logic [GRPS-1:0] grp_free(input logic [SLOT_SPAN-1:0] used);
        logic [GRPS-1:0] g;
        g = '0;
        for (int k = 0; k < SLOT_SPAN; k++) begin
            if (!used[k] && k < SWITCH_SLOTS) begin
                g[k / GRP_SIZE] = 1'b1;
            end
        end
        return g;
    endfunction

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.clr_all) begin
            n_slot = '0;
        end else if (i_cmd.set) begin
            n_slot[i_cmd.idx] = 1'b1;
        end else if (i_cmd.clr) begin
            n_slot[i_cmd.idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_grp_free <= grp_free('0);
        end else begin
            r_slot     <= n_slot;
            r_grp_free <= grp_free(n_slot);
        end
    end

    always_comb begin
        for (int k = 0; k < SLOT_SPAN; k++) begin
            w_free[k] = !r_slot[k] && (k < SWITCH_SLOTS);
        end
        w_grp_sel = '0;
        for (int g = GRPS - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                w_grp_sel = GRP_AW'(g);
            end
        end
        w_grp_bits = w_free[w_grp_sel * GRP_SIZE +: GRP_SIZE];
        w_bit_sel  = '0;
        for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (w_grp_bits[b]) begin
                w_bit_sel = GRP_BITS'(b);
            end
        end
    end

    assign o_free_found = |r_grp_free;
    assign o_free_idx   = {w_grp_sel, w_bit_sel};
    assign o_in_use     = r_slot[i_query];

endmodule

`default_nettype wire

/* sv/object_handle_allocator_core.sv */
// ----------------------------------------------------------------------------
// object_handle_allocator_core
// Allocates, releases and decodes 64-bit object handles built from context,
// switch slot, type and index fields.
//
//   Channel   Handshake                      Payload
//   command   start / busy                   i_mode, i_object_type, i_id_operand
//   result    o_done strobe, one cycle       o_handle_out, o_type_out, o_status
//   config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_wdata
//
// Every operation reads the counter table in the cycle of the transfer and
// writes any update back in the next, when the result is registered. The
// registered read port of the counter memory sets this.
// Reset and clear take effect at once through valid bits; no clearing pass.
// Results cannot be stalled; a new command can be taken in the result cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module object_handle_allocator_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [2:0]           i_mode,
    input  wire ohalloc_pkg::t_field  i_object_type,
    input  wire ohalloc_pkg::t_handle i_id_operand,
    output logic                      o_done,
    output ohalloc_pkg::t_handle      o_handle_out,
    output ohalloc_pkg::t_field       o_type_out,
    output logic [2:0]                o_status,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire ohalloc_pkg::t_field  i_cfg_wdata
);
    import ohalloc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state  r_state;
    logic    r_busy;
    logic    r_done;
    t_handle r_handle;
    t_field  r_tout;
    t_status r_status;

    logic [2:0] r_mode;
    t_field     r_otype;
    t_handle    r_id;
    t_field     r_cfg_ctx;
    t_field     r_cfg_sw;
    t_field     r_cfg_lim;

    logic               w_accept;
    logic [TYPE_AW-1:0] w_rd_addr;
    logic [CTR_W-1:0]   w_ctr;
    t_ctr_wr            w_ctr_wr;
    t_slot_cmd          w_slot_cmd;
    logic               w_in_use;
    logic               w_free_found;
    t_field             w_free_idx;

    t_handle n_handle;
    t_field  n_tout;
    t_status n_status;

    t_field  w_dec;
    t_field  w_tf;
    t_field  w_sf;
    logic    w_exec;

    assign w_accept    = start && !r_busy;
    assign w_rd_addr   = (i_mode == MODE_ALLOC) ? TYPE_AW'(i_object_type)
                                                : TYPE_AW'(type_field(i_id_operand));
    assign o_cfg_ready = 1'b1;

    ohalloc_ctr_mem u_ctr_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr      (w_ctr_wr),
        .o_rd_data (w_ctr)
    );

    ohalloc_slot_map u_slot_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_slot_cmd),
        .i_query      (w_sf),
        .o_in_use     (w_in_use),
        .o_free_found (w_free_found),
        .o_free_idx   (w_free_idx)
    );

    always_comb begin
        w_exec     = (r_state == S_EXEC);
        w_dec      = decode_type(r_id, r_cfg_lim);
        w_tf       = type_field(r_id);
        w_sf       = slot_field(r_id);
        n_handle   = '0;
        n_tout     = '0;
        n_status   = ST_OK;
        w_slot_cmd = '0;
        w_ctr_wr   = '0;
        w_slot_cmd.idx = w_sf;
        w_ctr_wr.addr  = TYPE_AW'(r_otype);
        case (r_mode)
            MODE_ALLOC: begin
                if (r_otype == '0 || r_otype >= r_cfg_lim || !type_in_table(r_otype)) begin
                    n_status = ST_BAD_TYPE;
                end else if (r_otype == r_cfg_sw) begin
                    if (!w_free_found) begin
                        n_status = ST_NO_SLOT;
                    end else begin
                        w_slot_cmd.set = w_exec;
                        w_slot_cmd.idx = w_free_idx;
                        n_handle = make_handle(r_cfg_ctx, w_free_idx, r_otype,
                                               INDEX_BITS'(w_free_idx));
                    end
                end else if (w_dec == '0 || w_dec != r_cfg_sw) begin
                    n_status = ST_NOT_SWITCH;
                end else if (w_ctr[INDEX_BITS]) begin
                    n_status = ST_EXHAUSTED;
                end else begin
                    w_ctr_wr.en   = w_exec;
                    w_ctr_wr.data = w_ctr + CTR_W'(1);
                    n_handle = make_handle(r_cfg_ctx, w_sf, r_otype,
                                           w_ctr[INDEX_BITS-1:0]);
                end
            end
            MODE_RELEASE: begin
                if (w_dec != '0 && w_dec == r_cfg_sw) begin
                    if (!slot_in_range(w_sf) || !w_in_use) begin
                        n_status = ST_NOT_IN_USE;
                    end else begin
                        w_slot_cmd.clr = w_exec;
                    end
                end
            end
            MODE_SW_QUERY: begin
                if (r_id != '0) begin
                    if (w_dec == '0) begin
                        n_status = ST_BAD_TYPE;
                    end else if (w_dec == r_cfg_sw) begin
                        n_handle = r_id;
                    end else begin
                        n_handle = make_handle(r_cfg_ctx, w_sf, r_cfg_sw,
                                               INDEX_BITS'(w_sf));
                    end
                end
            end
            MODE_TYPE_QUERY: begin
                n_tout = w_dec;
            end
            MODE_WARM_BOOT: begin
                w_ctr_wr.addr = TYPE_AW'(w_tf);
                if (w_tf >= r_cfg_lim || !type_in_table(w_tf)) begin
                    n_status = ST_BAD_TYPE;
                end else if (w_ctr <= {1'b0, r_id[INDEX_BITS-1:0]}) begin
                    w_ctr_wr.en   = w_exec;
                    w_ctr_wr.data = {1'b0, r_id[INDEX_BITS-1:0]} + CTR_W'(1);
                end
            end
            MODE_CLEAR: begin
                w_slot_cmd.clr_all = w_exec;
                w_ctr_wr.clr_all   = w_exec;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_mode;
            r_otype <= i_object_type;
            r_id    <= i_id_operand;
        end
        if (w_exec) begin
            r_handle <= n_handle;
            r_tout   <= n_tout;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ctx <= '0;
            r_cfg_sw  <= 8'd33;
            r_cfg_lim <= 8'd255;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CONTEXT:     r_cfg_ctx <= i_cfg_wdata;
                CFG_SWITCH_TYPE: r_cfg_sw  <= i_cfg_wdata;
                CFG_TYPE_LIMIT:  r_cfg_lim <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (w_accept) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
            endcase
        end
    end

    assign busy         = r_busy;
    assign o_done       = r_done;
    assign o_handle_out = r_handle;
    assign o_type_out   = r_tout;
    assign o_status     = r_status;

    `AM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `AM_ASSERT_NXT(a_busy_done, i_clk, i_rst_n, busy, o_done && !busy)
    `AM_ASSERT_IMP(a_err_no_handle, i_clk, i_rst_n, o_done && o_status != ST_OK, o_handle_out == '0)
    `AM_ASSERT_IMP(a_type_only, i_clk, i_rst_n, o_done && o_type_out != '0, o_handle_out == '0 && o_status == ST_OK)

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Object handle allocator testbench
// Drives allocate, release, query, warm-boot and clear commands into the core
// under several register settings. Every result is checked field by field
// against a cycle-free model of the slot bitmap and the per-type counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ohalloc_pkg::*;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        t_handle handle;
        t_field  obj_type;
        t_status status;
    } t_op_result;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic [2:0] i_mode      = '0;
    t_field     i_object_type = '0;
    t_handle    i_id_operand  = '0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = '0;
    t_field     i_cfg_wdata = '0;
    logic       busy;
    logic       o_done;
    t_handle    o_handle_out;
    t_field     o_type_out;
    logic [2:0] o_status;
    logic       o_cfg_ready;

    t_field           cfg_ctx     = 8'd0;
    t_field           cfg_sw_type = 8'd33;
    t_field           cfg_limit   = 8'd255;
    bit               slot_taken [SWITCH_SLOTS];
    logic [CTR_W-1:0] type_counter [TYPE_SLOTS];

    t_op_result  pending_results[$];
    int unsigned err_cnt = 0;
    bit          gaps_on = 1'b1;

    object_handle_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_object_type (i_object_type),
        .i_id_operand  (i_id_operand),
        .o_done        (o_done),
        .o_handle_out  (o_handle_out),
        .o_type_out    (o_type_out),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_handle rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_handle build_handle(input t_field typ, input t_field slot,
                                             input logic [31:0] idx);
        return {8'h00, cfg_ctx, slot, typ, idx};
    endfunction

    function automatic t_field handle_type(input t_handle h);
        t_field t;
        t = h[39:32];
        if (h == '0 || t == '0 || t >= cfg_limit) begin
            return '0;
        end
        return t;
    endfunction

    function automatic bit names_switch(input t_field t);
        return t != '0 && t == cfg_sw_type;
    endfunction

    function automatic void clear_tables();
        int i;
        for (i = 0; i < SWITCH_SLOTS; i++) slot_taken[i] = 1'b0;
        for (i = 0; i < TYPE_SLOTS; i++) type_counter[i] = '0;
    endfunction

    function automatic t_op_result apply_handle_op(input logic [2:0] mode, input t_field otype,
                                                   input t_handle id);
        t_op_result       r;
        int               i;
        int               found;
        t_field           t;
        t_field           s;
        logic [CTR_W-1:0] idx;
        r.handle   = '0;
        r.obj_type = '0;
        r.status   = ST_OK;
        found      = -1;
        case (mode)
            MODE_ALLOC: begin
                if (otype == '0 || otype >= cfg_limit) begin
                    r.status = ST_BAD_TYPE;
                end else if (names_switch(otype)) begin
                    for (i = 0; i < SWITCH_SLOTS; i++) begin
                        if (!slot_taken[i] && found < 0) found = i;
                    end
                    if (found < 0) begin
                        r.status = ST_NO_SLOT;
                    end else begin
                        slot_taken[found] = 1'b1;
                        r.handle = build_handle(otype, t_field'(found), 32'(found));
                    end
                end else if (!names_switch(handle_type(id))) begin
                    r.status = ST_NOT_SWITCH;
                end else begin
                    idx = type_counter[otype];
                    if (idx > 33'h0_FFFF_FFFF) begin
                        r.status = ST_EXHAUSTED;
                    end else begin
                        type_counter[otype] = idx + 33'd1;
                        r.handle = build_handle(otype, id[47:40], idx[31:0]);
                    end
                end
            end
            MODE_RELEASE: begin
                if (names_switch(handle_type(id))) begin
                    s = id[47:40];
                    if (int'(s) >= SWITCH_SLOTS || !slot_taken[s]) begin
                        r.status = ST_NOT_IN_USE;
                    end else begin
                        slot_taken[s] = 1'b0;
                    end
                end
            end
            MODE_SW_QUERY: begin
                if (id != '0) begin
                    t = handle_type(id);
                    s = id[47:40];
                    if (t == '0) begin
                        r.status = ST_BAD_TYPE;
                    end else if (names_switch(t)) begin
                        r.handle = id;
                    end else begin
                        r.handle = build_handle(cfg_sw_type, s, {24'h0, s});
                    end
                end
            end
            MODE_TYPE_QUERY: begin
                r.obj_type = handle_type(id);
            end
            MODE_WARM_BOOT: begin
                t = id[39:32];
                if (t >= cfg_limit) begin
                    r.status = ST_BAD_TYPE;
                end else if (type_counter[t] <= {1'b0, id[31:0]}) begin
                    type_counter[t] = {1'b0, id[31:0]} + 33'd1;
                end
            end
            MODE_CLEAR: begin
                clear_tables();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_op_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no command outstanding: handle_out %h", o_handle_out);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_handle_out !== want.handle) begin
                    $error("handle_out mismatch: expected %h, got %h", want.handle, o_handle_out);
                    err_cnt++;
                end
                if (o_type_out !== want.obj_type) begin
                    $error("type_out mismatch: expected %0d, got %0d", want.obj_type, o_type_out);
                    err_cnt++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, o_status);
                    err_cnt++;
                end
            end
        end
    end

    task automatic send_cmd(input logic [2:0] mode, input t_field otype, input t_handle id);
        start         <= 1'b1;
        i_mode        <= mode;
        i_object_type <= otype;
        i_id_operand  <= id;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(apply_handle_op(mode, otype, id));
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_field val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CONTEXT:     cfg_ctx     = val;
            CFG_SWITCH_TYPE: cfg_sw_type = val;
            CFG_TYPE_LIMIT:  cfg_limit   = val;
            default: begin
            end
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_handle switch_handle(input t_field slot);
        return build_handle(cfg_sw_type, slot, {24'h0, slot});
    endfunction

    function automatic t_field pick_slot();
        if ($urandom_range(0, 9) == 0) return t_field'($urandom_range(0, 255));
        return t_field'($urandom_range(0, 15));
    endfunction

    task automatic send_random_item();
        int      sel;
        int      pick;
        t_field  ot;
        t_handle id;
        sel = $urandom_range(0, 99);
        id  = rand64();
        ot  = t_field'($urandom);
        if (sel < 35 || sel >= 96) begin
            pick = $urandom_range(0, 9);
            if (pick < 3 || sel >= 96) ot = cfg_sw_type;
            else if (pick < 9) ot = t_field'($urandom_range(1, cfg_limit - 1));
            if ($urandom_range(0, 4) != 0) id = switch_handle(pick_slot());
            send_cmd(MODE_ALLOC, ot, id);
        end else if (sel < 50) begin
            if ($urandom_range(0, 3) != 0) id = switch_handle(pick_slot());
            send_cmd(MODE_RELEASE, ot, id);
        end else if (sel < 62) begin
            case ($urandom_range(0, 3))
                0: id = '0;
                1: id = switch_handle(pick_slot());
                2: id[39:32] = t_field'($urandom_range(1, cfg_limit - 1));
                default: begin
                end
            endcase
            send_cmd(MODE_SW_QUERY, ot, id);
        end else if (sel < 74) begin
            if ($urandom_range(0, 1) == 0) id[39:32] = cfg_limit - t_field'($urandom_range(0, 1));
            send_cmd(MODE_TYPE_QUERY, ot, id);
        end else if (sel < 90) begin
            if ($urandom_range(0, 19) != 0) id[39:32] = t_field'($urandom_range(0, cfg_limit - 1));
            pick = $urandom_range(0, 9);
            if (pick < 8) id[31:0] = $urandom_range(0, 300);
            else if (pick == 8) id[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 3);
            send_cmd(MODE_WARM_BOOT, ot, id);
        end else if (sel < 92) begin
            send_cmd(MODE_CLEAR, ot, id);
        end else begin
            send_cmd(($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7, ot, id);
        end
    endtask

    task automatic run_random_traffic(input int count);
        repeat (count) begin
            send_random_item();
            if (gaps_on && $urandom_range(0, 49) == 0) wait_all_results();
        end
    endtask

    task automatic test_directed_ops();
        t_handle plain;
        plain = {16'h0000, 8'd3, 8'd5, 32'd7};
        send_cmd(MODE_ALLOC, cfg_sw_type, 64'hDEAD_BEEF_0123_4567);
        send_cmd(MODE_ALLOC, 8'd0, switch_handle(8'd0));
        send_cmd(MODE_ALLOC, 8'd255, switch_handle(8'd0));
        send_cmd(MODE_ALLOC, 8'd5, switch_handle(8'd0));
        send_cmd(MODE_ALLOC, 8'd5, switch_handle(8'd0));
        send_cmd(MODE_ALLOC, 8'd5, '0);
        send_cmd(MODE_ALLOC, 8'd5, plain);
        send_cmd(MODE_TYPE_QUERY, 8'hFF, '0);
        send_cmd(MODE_TYPE_QUERY, 8'h00, '1);
        send_cmd(MODE_TYPE_QUERY, 8'h00, switch_handle(8'd0));
        send_cmd(MODE_SW_QUERY, 8'h00, '0);
        send_cmd(MODE_SW_QUERY, 8'h00, '1);
        send_cmd(MODE_SW_QUERY, 8'h00, switch_handle(8'd0));
        send_cmd(MODE_SW_QUERY, 8'h00, plain);
        send_cmd(MODE_RELEASE, 8'h00, plain);
        send_cmd(MODE_RELEASE, 8'h00, switch_handle(8'd9));
        send_cmd(MODE_RELEASE, 8'h00, switch_handle(8'd255));
        send_cmd(MODE_RELEASE, 8'h00, switch_handle(8'd0));
        send_cmd(MODE_RELEASE, 8'h00, switch_handle(8'd0));
        send_cmd(MODE_WARM_BOOT, 8'h00, {24'h0, 8'd0, 32'd10});
        send_cmd(MODE_WARM_BOOT, 8'h00, {24'h0, 8'd255, 32'd10});
        send_cmd(MODE_WARM_BOOT, 8'h00, {24'h0, 8'd5, 32'd0});
        send_cmd(MODE_SPARE_6, 8'hFF, '1);
        send_cmd(MODE_SPARE_7, 8'hFF, '1);
        send_cmd(MODE_CLEAR, 8'h00, '0);
    endtask

    task automatic test_switch_slot_exhaustion();
        repeat (SWITCH_SLOTS + 1) send_cmd(MODE_ALLOC, cfg_sw_type, '0);
        send_cmd(MODE_RELEASE, 8'h00, switch_handle(8'd100));
        send_cmd(MODE_ALLOC, cfg_sw_type, '0);
        send_cmd(MODE_ALLOC, cfg_sw_type, '0);
        wait_all_results();
        send_cmd(MODE_CLEAR, 8'h00, '0);
    endtask

    task automatic test_index_exhaustion();
        send_cmd(MODE_ALLOC, cfg_sw_type, '0);
        send_cmd(MODE_WARM_BOOT, 8'h00, {24'h0, 8'd7, 32'hFFFF_FFFE});
        send_cmd(MODE_ALLOC, 8'd7, switch_handle(8'd0));
        send_cmd(MODE_ALLOC, 8'd7, switch_handle(8'd0));
        send_cmd(MODE_WARM_BOOT, 8'h00, {24'h0, 8'd7, 32'd3});
        send_cmd(MODE_ALLOC, 8'd7, switch_handle(8'd0));
        send_cmd(MODE_WARM_BOOT, 8'h00, {24'h0, 8'd9, 32'hFFFF_FFFF});
        send_cmd(MODE_ALLOC, 8'd9, switch_handle(8'd0));
        send_cmd(MODE_CLEAR, 8'h00, '0);
        send_cmd(MODE_ALLOC, 8'd7, switch_handle(8'd0));
    endtask

    task automatic run_setting(input t_field ctx, input t_field sw, input t_field limit,
                               input int count);
        wait_all_results();
        write_reg(CFG_CONTEXT, ctx);
        write_reg(CFG_SWITCH_TYPE, sw);
        write_reg(CFG_TYPE_LIMIT, limit);
        run_random_traffic(count);
    endtask

    task automatic test_register_settings();
        t_field sw;
        run_setting(8'hA5, 8'd33, 8'd255, 20);
        run_setting(8'hFF, 8'd254, 8'd255, 20);
        run_setting(8'h00, 8'd1, 8'd2, 10);
        run_setting(8'h3C, 8'd254, 8'd2, 10);
        sw = t_field'($urandom_range(1, 200));
        run_setting(t_field'($urandom), sw, t_field'($urandom_range(sw + 1, 255)), 20);
        run_setting(t_field'($urandom), t_field'($urandom_range(1, 254)),
                    t_field'($urandom_range(2, 255)), 10);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_setting(8'h5A, 8'd33, 8'd200, 30);
    endtask

    initial begin
        clear_tables();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_switch_slot_exhaustion();
        test_index_exhaustion();
        test_register_settings();
        test_back_to_back();
        wait_all_results();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
